[hw/rtl/ibcs_pkg.sv]
// shared types and constants for the imu bias calibration and smoothing block
package ibcs_pkg;

  localparam int RAW_W      = 16;  // raw sensor count
  localparam int SUM_W      = 25;  // calibration sum per axis
  localparam int MEAN_W     = 24;  // bias in q8 counts
  localparam int FILT_W     = 26;  // filter state in q8 counts
  localparam int DIFF_W     = 27;  // x - y
  localparam int P1_W       = 37;  // alpha * (x - y)
  localparam int ALPHA_W    = 9;
  localparam int SCALE_W    = 24;
  localparam int ONEG_W     = 15;
  localparam int P2_W       = 51;  // y * scale
  localparam int ACC_W      = 16;
  localparam int GYR_W      = 20;
  localparam int U_W        = 24;  // calibration sum offset to non-negative
  localparam int QA_W       = 16;  // coarse quotient of the offset sum
  localparam int RA_W       = 8;   // remainder of the coarse quotient
  localparam int NACC       = 3;
  localparam int NGYR       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int CAL_SAMPLES_DEF = 100;
  localparam int CAL_SAMPLES_MAX = 256;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 9'd128;
  localparam logic [SCALE_W-1:0] ACC_SCL_RST = 24'd20073;
  localparam logic [SCALE_W-1:0] GYR_SCL_RST = 24'd293601;
  localparam logic [ONEG_W-1:0]  ONEG_RST    = 15'd8197;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA     = 3'd0,
    REG_ACC_SCALE = 3'd1,
    REG_GYR_SCALE = 3'd2,
    REG_ONE_G     = 3'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_LD,
    ST_DIV,
    ST_MEAN,
    ST_CAL_OUT,
    ST_DIFF,
    ST_MUL1,
    ST_UPD,
    ST_MUL2,
    ST_RND
  } state_t;

  typedef struct packed {
    logic ld_raw;   // capture raw sample
    logic acc;      // add raw sample into calibration sum
    logic div_ld;   // coarse quotient of the offset sum
    logic div_step; // remainder of the coarse quotient
    logic mean_ld;  // fine quotient, bias load
    logic diff;
    logic mul1;
    logic upd;
    logic mul2;
  } lane_ctl_t;

endpackage

[hw/rtl/ibcs_in_if.sv]
// input channel: one six-axis raw sample per transfer
interface ibcs_in_if import ibcs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] accel_x_raw;
  logic signed [RAW_W-1:0] accel_y_raw;
  logic signed [RAW_W-1:0] accel_z_raw;
  logic signed [RAW_W-1:0] gyro_x_raw;
  logic signed [RAW_W-1:0] gyro_y_raw;
  logic signed [RAW_W-1:0] gyro_z_raw;

  modport source (
    output valid, accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );
  modport sink (
    input  valid, accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

[hw/rtl/ibcs_out_if.sv]
// result channel: filtered six-axis values per transfer
interface ibcs_out_if import ibcs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    ready_res;
  logic signed [ACC_W-1:0] accel_x_filt;
  logic signed [ACC_W-1:0] accel_y_filt;
  logic signed [ACC_W-1:0] accel_z_filt;
  logic signed [GYR_W-1:0] gyro_x_filt;
  logic signed [GYR_W-1:0] gyro_y_filt;
  logic signed [GYR_W-1:0] gyro_z_filt;

  modport source (
    output valid, ready_res, accel_x_filt, accel_y_filt, accel_z_filt,
           gyro_x_filt, gyro_y_filt, gyro_z_filt,
    input  ready
  );
  modport sink (
    input  valid, ready_res, accel_x_filt, accel_y_filt, accel_z_filt,
           gyro_x_filt, gyro_y_filt, gyro_z_filt,
    output ready
  );
endinterface

[hw/rtl/ibcs_lane.sv]
// one axis: calibration sum, bias divider, low-pass filter and output scaling
module ibcs_lane import ibcs_pkg::*; #(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
  parameter int OUT_W       = ACC_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lane_ctl_t                 ctl,
  input  logic signed [RAW_W-1:0]   raw_in,
  input  logic [ALPHA_W-1:0]        alpha,
  input  logic [SCALE_W-1:0]        scale,
  input  logic [MEAN_W-1:0]         grav_q8,
  output logic signed [OUT_W-1:0]   res
);

  // reciprocal constants for exact floor division by the sample count
  localparam int DIV_L = $clog2(CAL_SAMPLES);
  localparam int N2_W  = RA_W + 8;
  localparam int S1    = U_W + DIV_L;
  localparam int S2    = N2_W + DIV_L;
  localparam int M1_W  = U_W + 1;
  localparam int M2_W  = N2_W + 1;
  localparam int PQ1_W = U_W + M1_W;
  localparam int PQ2_W = N2_W + M2_W;
  localparam logic [M1_W-1:0]  M1 = M1_W'(((64'd1 << S1) + 64'(CAL_SAMPLES) - 64'd1)
                                          / 64'(CAL_SAMPLES));
  localparam logic [M2_W-1:0]  M2 = M2_W'(((64'd1 << S2) + 64'(CAL_SAMPLES) - 64'd1)
                                          / 64'(CAL_SAMPLES));
  localparam logic [SUM_W-1:0] U_OFS  = SUM_W'(CAL_SAMPLES) << (RAW_W - 1);
  localparam logic [U_W-1:0]   N_U    = U_W'(CAL_SAMPLES);
  localparam logic [N2_W-1:0]  HALF_N = N2_W'(CAL_SAMPLES / 2);

  localparam logic signed [P1_W-1:0] HALF8  = P1_W'(128);
  localparam logic signed [P1_W-1:0] Y_MAX  = (P1_W'(1) <<< (FILT_W - 1)) - P1_W'(1);
  localparam logic signed [P1_W-1:0] Y_MIN  = -(P1_W'(1) <<< (FILT_W - 1));
  localparam logic signed [P2_W-1:0] HALF24 = P2_W'(1) <<< 23;
  localparam logic signed [P2_W-1:0] R_MAX  = (P2_W'(1) <<< (OUT_W - 1)) - P2_W'(1);
  localparam logic signed [P2_W-1:0] R_MIN  = -(P2_W'(1) <<< (OUT_W - 1));

  logic signed [SUM_W-1:0]  sum_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic signed [FILT_W-1:0] y_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic [QA_W-1:0]          qa_r;
  logic [RA_W-1:0]          ra_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [P1_W-1:0]   prod1_r;
  logic signed [P2_W-1:0]   prod2_r;

  logic [SUM_W-1:0]         u_full;
  logic [U_W-1:0]           u_val;
  logic [PQ1_W-1:0]         pq1;
  logic [U_W-1:0]           ra_full;
  logic [N2_W-1:0]          n2;
  logic [PQ2_W-1:0]         pq2;
  logic [7:0]               q2;
  logic signed [MEAN_W-1:0] raw_q8;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [ALPHA_W:0]  alpha_s;
  logic signed [SCALE_W:0]  scale_s;
  logic signed [P1_W-1:0]   inc;
  logic signed [P1_W-1:0]   y_sum;
  logic signed [FILT_W-1:0] y_nxt;
  logic signed [P2_W-1:0]   r_full;

  // bias = round(sum * 256 / n): sum offset by n * 32768 so it stays non-negative,
  // then split into coarse quotient, remainder and fine quotient of remainder * 256
  always_comb begin
    u_full  = sum_r + U_OFS;
    u_val   = u_full[U_W-1:0];
    pq1     = PQ1_W'(u_val) * PQ1_W'(M1);
    ra_full = u_val - U_W'(qa_r) * N_U;
    n2      = {ra_r, 8'd0} + HALF_N;
    pq2     = PQ2_W'(n2) * PQ2_W'(M2);
    q2      = pq2[S2 +: 8];
  end

  always_comb begin
    raw_q8   = {raw_r, 8'd0};
    diff_nxt = DIFF_W'(raw_q8) - DIFF_W'(mean_r) + $signed({3'd0, grav_q8})
               - DIFF_W'(y_r);
    alpha_s  = $signed({1'b0, alpha});
    scale_s  = $signed({1'b0, scale});
    inc      = (prod1_r + HALF8) >>> 8;
    y_sum    = inc + P1_W'(y_r);
    if (y_sum > Y_MAX) begin
      y_nxt = Y_MAX[FILT_W-1:0];
    end else if (y_sum < Y_MIN) begin
      y_nxt = Y_MIN[FILT_W-1:0];
    end else begin
      y_nxt = y_sum[FILT_W-1:0];
    end
    r_full = (prod2_r + HALF24) >>> 24;
    if (r_full > R_MAX) begin
      res = R_MAX[OUT_W-1:0];
    end else if (r_full < R_MIN) begin
      res = R_MIN[OUT_W-1:0];
    end else begin
      res = r_full[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      mean_r <= '0;
      y_r    <= '0;
    end else begin
      if (ctl.acc) begin
        sum_r <= sum_r + SUM_W'(raw_in);
      end
      // removing the offset again flips the top bit
      if (ctl.mean_ld) begin
        mean_r <= {~qa_r[QA_W-1], qa_r[QA_W-2:0], q2};
      end
      if (ctl.upd) begin
        y_r <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_raw) begin
      raw_r <= raw_in;
    end
    if (ctl.div_ld) begin
      qa_r <= pq1[S1 +: QA_W];
    end
    if (ctl.div_step) begin
      ra_r <= ra_full[RA_W-1:0];
    end
    if (ctl.diff) begin
      diff_r <= diff_nxt;
    end
    if (ctl.mul1) begin
      prod1_r <= P1_W'(alpha_s) * P1_W'(diff_r);
    end
    if (ctl.mul2) begin
      prod2_r <= P2_W'(y_r) * P2_W'(scale_s);
    end
  end

endmodule

[hw/rtl/ibcs_merge.sv]
// merges the six lane results into one output register toward the result channel
module ibcs_merge import ibcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic                    rdy,
  input  logic signed [ACC_W-1:0] acc_res [NACC],
  input  logic signed [GYR_W-1:0] gyr_res [NGYR],
  output logic                    free,
  ibcs_out_if.source              out_ch
);

  logic                    valid_r;
  logic                    rdy_r;
  logic signed [ACC_W-1:0] acc_r [NACC];
  logic signed [GYR_W-1:0] gyr_r [NGYR];

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // calibrating samples go out as all zero
  always_ff @(posedge clk) begin
    if (load) begin
      rdy_r <= rdy;
      for (int i = 0; i < NACC; i++) begin
        acc_r[i] <= rdy ? acc_res[i] : '0;
      end
      for (int i = 0; i < NGYR; i++) begin
        gyr_r[i] <= rdy ? gyr_res[i] : '0;
      end
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.ready_res    = rdy_r;
  assign out_ch.accel_x_filt = acc_r[0];
  assign out_ch.accel_y_filt = acc_r[1];
  assign out_ch.accel_z_filt = acc_r[2];
  assign out_ch.gyro_x_filt  = gyr_r[0];
  assign out_ch.gyro_y_filt  = gyr_r[1];
  assign out_ch.gyro_z_filt  = gyr_r[2];

endmodule

[hw/rtl/imu_bias_calibrate_and_smooth_core.sv]
// top level: control sequencer, config registers, six axis lanes and output merge
// throughput: once calibrated, each sample runs five lane steps (diff, mul1, upd, mul2, rnd)
//   before the next is taken, and rnd holds while the output register is full; a calibrating
//   sample goes to cal_out, the last after the three-step bias division in every lane, then load
// the output register lets a new sample be taken while a result waits
// reset (synchronous, rst_n low) clears calibration, sums, bias and filter state
module imu_bias_calibrate_and_smooth_core import ibcs_pkg::*; #(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ibcs_in_if.sink               in_ch,
  ibcs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

  state_t              state_r;
  state_t              state_nxt;
  logic                cal_done_r;
  logic [CNT_W-1:0]    cal_cnt_r;
  logic [ALPHA_W-1:0]  alpha_r;
  logic [SCALE_W-1:0]  acc_scale_r;
  logic [SCALE_W-1:0]  gyr_scale_r;
  logic [ONEG_W-1:0]   one_g_r;

  lane_ctl_t           ctl;
  logic                in_xfer;
  logic                mrg_load;
  logic                mrg_rdy;
  logic                mrg_free;
  logic [ALPHA_W-1:0]  alpha_eff;

  logic signed [RAW_W-1:0] raw_in  [NACC + NGYR];
  logic signed [ACC_W-1:0] acc_res [NACC];
  logic signed [GYR_W-1:0] gyr_res [NGYR];

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  assign raw_in[0] = in_ch.accel_x_raw;
  assign raw_in[1] = in_ch.accel_y_raw;
  assign raw_in[2] = in_ch.accel_z_raw;
  assign raw_in[3] = in_ch.gyro_x_raw;
  assign raw_in[4] = in_ch.gyro_y_raw;
  assign raw_in[5] = in_ch.gyro_z_raw;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RST;
      acc_scale_r <= ACC_SCL_RST;
      gyr_scale_r <= GYR_SCL_RST;
      one_g_r     <= ONEG_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_ALPHA:     alpha_r     <= cfg_wdata[ALPHA_W-1:0];
        REG_ACC_SCALE: acc_scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_GYR_SCALE: gyr_scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_ONE_G:     one_g_r     <= cfg_wdata[ONEG_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cal_done_r) begin
            state_nxt = ST_DIFF;
          end else if (cal_cnt_r == CNT_LAST) begin
            state_nxt = ST_DIV_LD;
          end else begin
            state_nxt = ST_CAL_OUT;
          end
        end
      end
      ST_DIV_LD: state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_MEAN;
      ST_MEAN:   state_nxt = ST_CAL_OUT;
      ST_CAL_OUT: begin
        if (mrg_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIFF: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_RND;
      ST_RND: begin
        if (mrg_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl         = '0;
    in_ch.ready = 1'b0;
    mrg_load    = 1'b0;
    mrg_rdy     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.ld_raw  = in_xfer;
        ctl.acc     = in_xfer && !cal_done_r;
      end
      ST_DIV_LD:  ctl.div_ld   = 1'b1;
      ST_DIV:     ctl.div_step = 1'b1;
      ST_MEAN:    ctl.mean_ld  = 1'b1;
      ST_CAL_OUT: mrg_load     = mrg_free;
      ST_DIFF:    ctl.diff     = 1'b1;
      ST_MUL1:    ctl.mul1     = 1'b1;
      ST_UPD:     ctl.upd      = 1'b1;
      ST_MUL2:    ctl.mul2     = 1'b1;
      ST_RND: begin
        mrg_load = mrg_free;
        mrg_rdy  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cal_done_r <= 1'b0;
      cal_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.acc) begin
        cal_cnt_r <= cal_cnt_r + CNT_W'(1);
      end
      if (ctl.mean_ld) begin
        cal_done_r <= 1'b1;
      end
    end
  end

  for (genvar i = 0; i < NACC; i++) begin : g_acc
    logic [MEAN_W-1:0] grav;
    // gravity restored on accel z only
    if (i == NACC - 1) begin : g_z
      assign grav = MEAN_W'({one_g_r, 8'd0});
    end else begin : g_xy
      assign grav = '0;
    end
    ibcs_lane #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .OUT_W       (ACC_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .raw_in  (raw_in[i]),
      .alpha   (alpha_eff),
      .scale   (acc_scale_r),
      .grav_q8 (grav),
      .res     (acc_res[i])
    );
  end

  for (genvar i = 0; i < NGYR; i++) begin : g_gyr
    ibcs_lane #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .OUT_W       (GYR_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .raw_in  (raw_in[NACC + i]),
      .alpha   (alpha_eff),
      .scale   (gyr_scale_r),
      .grav_q8 ('0),
      .res     (gyr_res[i])
    );
  end

  ibcs_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (mrg_load),
    .rdy     (mrg_rdy),
    .acc_res (acc_res),
    .gyr_res (gyr_res),
    .free    (mrg_free),
    .out_ch  (out_ch)
  );

endmodule
